// ===== design/wws_pkg.sv =====
`timescale 1ns / 1ps
package wws_pkg;

	localparam int PIX_W       = 8;
	localparam int OCOL_W      = 10;
	localparam int OROW_W      = 12;
	localparam int WIDTH_REG_W = 11;
	localparam int HGT_REG_W   = 13;
	localparam int MAX_HEIGHT  = 4096;
	localparam int CFG_IDX_W   = 3;
	localparam int CFG_DATA_W  = 40;
	localparam int TDATA_W     = 32;

	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_WEIGHTS_ROW0 = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_WEIGHTS_ROW4 = 3'd6;

	typedef struct packed {
		logic accept;
		logic plan;
		logic acc_start;
		logic acc_issue;
		logic div_start;
		logic div_step;
		logic advance;
	} wws_cmd_t;

	typedef struct packed {
		logic has_results;
		logic tap_last;
		logic pipe_busy;
		logic div_last;
		logic more_results;
	} wws_sts_t;

endpackage

// ===== design/wws_ctrl.sv =====
`timescale 1ns / 1ps
module wws_ctrl import wws_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     s_tvalid,
	output logic     s_tready,
	output logic     m_tvalid,
	input  logic     m_tready,
	input  wws_sts_t sts,
	output wws_cmd_t cmd
);

	typedef enum logic [2:0] {
		S_IDLE, S_PLAN, S_ACC, S_DRAIN, S_DIV, S_OUT
	} state_t;

	state_t state_q;

	assign s_tready = (state_q == S_IDLE);
	assign m_tvalid = (state_q == S_OUT);

	always_comb begin
		cmd = '0;
		unique case (state_q)
			S_IDLE: cmd.accept = s_tvalid;
			S_PLAN: begin
				cmd.plan      = 1'b1;
				cmd.acc_start = sts.has_results;
			end
			S_ACC:   cmd.acc_issue = 1'b1;
			S_DRAIN: cmd.div_start = !sts.pipe_busy;
			S_DIV:   cmd.div_step  = 1'b1;
			S_OUT: begin
				cmd.acc_start = m_tready && sts.more_results;
				cmd.advance   = m_tready && sts.more_results;
			end
			default: cmd = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			unique case (state_q)
				S_IDLE:  if (s_tvalid) state_q <= S_PLAN;
				S_PLAN:  state_q <= sts.has_results ? S_ACC : S_IDLE;
				S_ACC:   if (sts.tap_last) state_q <= S_DRAIN;
				S_DRAIN: if (!sts.pipe_busy) state_q <= S_DIV;
				S_DIV:   if (sts.div_last) state_q <= S_OUT;
				S_OUT: begin
					if (m_tready) state_q <= sts.more_results ? S_ACC : S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	a_ready_not_valid: assert property (@(posedge clk) disable iff (!arst_n)
		s_tready |-> !m_tvalid) else $error("input taken while a word is pending");
	a_idle_pipe_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE) |-> !sts.pipe_busy) else $error("tap pipe busy in idle");
	a_div_after_drain: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DIV) && $past(state_q) != S_DIV |-> $past(state_q) == S_DRAIN)
		else $error("divide entered without drain");

endmodule

// ===== design/wws_datapath.sv =====
`timescale 1ns / 1ps
module wws_datapath import wws_pkg::*; #(
	parameter int MAX_WIDTH   = 1024,
	parameter int WEIGHT_BITS = 8
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_addr,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic [PIX_W-1:0]      pixel,
	input  wws_cmd_t              cmd,
	output wws_sts_t              sts,
	output logic [PIX_W-1:0]      smoothed_pixel,
	output logic [OCOL_W-1:0]     out_column,
	output logic [OROW_W-1:0]     out_row,
	output logic                  last_of_run,
	output logic                  end_of_image
);

	localparam int CW    = $clog2(MAX_WIDTH);
	localparam int EW    = ($clog2(MAX_WIDTH + 1) > WIDTH_REG_W) ?
	                       $clog2(MAX_WIDTH + 1) : WIDTH_REG_W;
	localparam int XW    = EW + 2;
	localparam int YW    = HGT_REG_W + 2;
	localparam int WROW  = 5 * WEIGHT_BITS;
	localparam int WS    = WEIGHT_BITS + 5;
	localparam int ACC_W = PIX_W + WEIGHT_BITS + 5;
	localparam int DCW   = $clog2(ACC_W);
	localparam int DEPTH = 5 * MAX_WIDTH;
	localparam int MAW   = $clog2(DEPTH);

	function automatic logic [WROW-1:0] wrow_rst(input int k);
		int base [5];
		logic [WROW-1:0] v;
		base = '{1, 2, 3, 2, 1};
		v = '0;
		for (int j = 0; j < 5; j++) begin
			v[j*WEIGHT_BITS +: WEIGHT_BITS] = WEIGHT_BITS'(base[k] * base[j]);
		end
		return v;
	endfunction

	logic [WIDTH_REG_W-1:0] w_q;
	logic [HGT_REG_W-1:0]   h_q;
	logic [WROW-1:0]        wrow_q [5];
	logic [CW-1:0]          c_q, cur_c_q, clo_q, chi_q, oc_q;
	logic [OROW_W-1:0]      r_q, cur_r_q, rhi_q, orow_q;
	logic [2:0]             slot_q, cur_slot_q, dy_q, dx_q;
	logic [PIX_W-1:0]       mem [DEPTH];
	logic [PIX_W-1:0]       rdata_s1;
	logic [WEIGHT_BITS-1:0] wt_s1, wt_s2;
	logic                   v_s1, v_s2;
	logic [PIX_W+WEIGHT_BITS-1:0] prod_s2;
	logic [ACC_W-1:0]       acc_q, dvd_q;
	logic [WS-1:0]          wsum_q, rem_q;
	logic [DCW-1:0]         dcnt_q;

	logic [EW-1:0]        ew;
	logic [HGT_REG_W-1:0] eh;
	logic                 wrap;
	logic [CW-1:0]        in_c;
	logic [OROW_W-1:0]    in_r;
	logic [2:0]           in_slot;
	logic                 c_end, r_end, cur_clast, cur_rlast;
	logic [XW-1:0]        fx_e;
	logic [YW-1:0]        fy_e;
	logic                 tap_in;
	logic [2:0]           row_back, tap_slot;
	logic [3:0]           slot_sum;
	logic [MAW-1:0]       raddr;
	logic [WS:0]          trial;
	logic                 ge;

	always_comb begin
		ew = EW'(w_q);
		if (w_q == '0) ew = EW'(1);
		else if (EW'(w_q) > EW'(MAX_WIDTH)) ew = EW'(MAX_WIDTH);
		eh = h_q;
		if (h_q == '0) eh = HGT_REG_W'(1);
		else if (h_q > HGT_REG_W'(MAX_HEIGHT)) eh = HGT_REG_W'(MAX_HEIGHT);
	end

	assign wrap    = (EW'(c_q) >= ew) || (HGT_REG_W'(r_q) >= eh);
	assign in_c    = wrap ? '0 : c_q;
	assign in_r    = wrap ? '0 : r_q;
	assign in_slot = wrap ? '0 : slot_q;
	assign c_end   = (EW'(in_c) + EW'(1)) >= ew;
	assign r_end   = (HGT_REG_W'(in_r) + HGT_REG_W'(1)) >= eh;

	assign cur_clast = (EW'(cur_c_q) == ew - EW'(1));
	assign cur_rlast = (HGT_REG_W'(cur_r_q) == eh - HGT_REG_W'(1));

	// window tap position and its bounds
	assign fx_e   = XW'(oc_q) + XW'(dx_q);
	assign fy_e   = YW'(orow_q) + YW'(dy_q);
	assign tap_in = (fx_e >= XW'(2)) && (fx_e - XW'(2) < XW'(ew))
	             && (fy_e >= YW'(2)) && (fy_e - YW'(2) < YW'(eh));
	assign row_back = 3'(YW'(cur_r_q) + YW'(2) - fy_e);
	assign slot_sum = 4'(cur_slot_q) + 4'd5 - 4'(row_back);
	assign tap_slot = (slot_sum >= 4'd5) ? 3'(slot_sum - 4'd5) : slot_sum[2:0];
	assign raddr    = MAW'(tap_slot * MAX_WIDTH) + MAW'(fx_e - XW'(2));

	assign trial = {rem_q, dvd_q[ACC_W-1]};
	assign ge    = trial >= (WS+1)'(wsum_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			w_q    <= WIDTH_REG_W'(1024);
			h_q    <= HGT_REG_W'(768);
			for (int k = 0; k < 5; k++) wrow_q[k] <= wrow_rst(k);
			c_q    <= '0;
			r_q    <= '0;
			slot_q <= '0;
			v_s1   <= 1'b0;
			v_s2   <= 1'b0;
		end else begin
			v_s1 <= cmd.acc_issue && tap_in;
			v_s2 <= v_s1;
			if (cmd.accept) begin
				c_q    <= c_end ? '0 : in_c + CW'(1);
				r_q    <= !c_end ? in_r : (r_end ? '0 : in_r + OROW_W'(1));
				slot_q <= !c_end ? in_slot :
				          (r_end ? '0 : ((in_slot == 3'd4) ? '0 : in_slot + 3'd1));
			end
			if (cfg_we) begin
				unique case (cfg_addr)
					REG_IMAGE_WIDTH: begin
						w_q    <= WIDTH_REG_W'(cfg_data);
						c_q    <= '0;
						r_q    <= '0;
						slot_q <= '0;
					end
					REG_IMAGE_HEIGHT: begin
						h_q    <= HGT_REG_W'(cfg_data);
						c_q    <= '0;
						r_q    <= '0;
						slot_q <= '0;
					end
					default: begin
						if (cfg_addr >= REG_WEIGHTS_ROW0 && cfg_addr <= REG_WEIGHTS_ROW4)
							wrow_q[cfg_addr - REG_WEIGHTS_ROW0] <= WROW'(cfg_data);
					end
				endcase
			end
		end
	end

	// line store
	always_ff @(posedge clk) begin
		if (cmd.accept) mem[MAW'(in_slot * MAX_WIDTH) + MAW'(in_c)] <= pixel;
		rdata_s1 <= mem[raddr];
	end

	always_ff @(posedge clk) begin
		wt_s1   <= wrow_q[dy_q][dx_q*WEIGHT_BITS +: WEIGHT_BITS];
		prod_s2 <= rdata_s1 * wt_s1;
		wt_s2   <= wt_s1;
		if (cmd.accept) begin
			cur_c_q    <= in_c;
			cur_r_q    <= in_r;
			cur_slot_q <= in_slot;
		end
		if (cmd.plan) begin
			clo_q  <= (cur_c_q >= CW'(2)) ? cur_c_q - CW'(2) : '0;
			chi_q  <= cur_clast ? cur_c_q : cur_c_q - CW'(2);
			rhi_q  <= cur_rlast ? cur_r_q : cur_r_q - OROW_W'(2);
			oc_q   <= (cur_c_q >= CW'(2)) ? cur_c_q - CW'(2) : '0;
			orow_q <= (cur_r_q >= OROW_W'(2)) ? cur_r_q - OROW_W'(2) : '0;
		end
		if (cmd.advance) begin
			if (oc_q == chi_q) begin
				oc_q   <= clo_q;
				orow_q <= orow_q + OROW_W'(1);
			end else begin
				oc_q <= oc_q + CW'(1);
			end
		end
		if (cmd.acc_start) begin
			dy_q   <= '0;
			dx_q   <= '0;
			acc_q  <= '0;
			wsum_q <= '0;
		end else begin
			if (cmd.acc_issue) begin
				if (dx_q == 3'd4) begin
					dx_q <= '0;
					dy_q <= dy_q + 3'd1;
				end else begin
					dx_q <= dx_q + 3'd1;
				end
			end
			if (v_s2) begin
				acc_q  <= acc_q + ACC_W'(prod_s2);
				wsum_q <= wsum_q + WS'(wt_s2);
			end
		end
		if (cmd.div_start) begin
			dvd_q  <= acc_q;
			rem_q  <= '0;
			dcnt_q <= '0;
		end else if (cmd.div_step) begin
			rem_q  <= ge ? WS'(trial - (WS+1)'(wsum_q)) : WS'(trial);
			dvd_q  <= {dvd_q[ACC_W-2:0], ge};
			dcnt_q <= dcnt_q + DCW'(1);
		end
	end

	assign sts.has_results  = (cur_clast || cur_c_q >= CW'(2))
	                       && (cur_rlast || cur_r_q >= OROW_W'(2));
	assign sts.tap_last     = (dy_q == 3'd4) && (dx_q == 3'd4);
	assign sts.pipe_busy    = v_s1 || v_s2;
	assign sts.div_last     = (dcnt_q == DCW'(ACC_W - 1));
	assign sts.more_results = !last_of_run;

	assign smoothed_pixel = (wsum_q == '0) ? '0 : dvd_q[PIX_W-1:0];
	assign out_column     = OCOL_W'(oc_q);
	assign out_row        = orow_q;
	assign last_of_run    = (oc_q == chi_q) && (orow_q == rhi_q);
	assign end_of_image   = (EW'(oc_q) == ew - EW'(1))
	                     && (HGT_REG_W'(orow_q) == eh - HGT_REG_W'(1));

endmodule

// ===== design/weighted_window_smoothing.sv =====
`timescale 1ns / 1ps
// 5x5 normalised smoothing filter on a raster-order 8-bit gray stream.
// s_tdata carries one pixel per word. Each pixel causes 0 to 9 result words
// on the m_ side, each the weighted mean of the in-bounds part of a 5x5
// window; m_tlast marks the last word caused by that pixel and m_tuser the
// final pixel of the image.
// Image size and the five weight rows are set through cfg_we/cfg_addr/
// cfg_data; the user must set them only while the block is idle, which the
// block itself does not enforce. Writing width or height restarts the frame.
// Pixels are taken one at a time: a pixel with no result passes only the
// idle and plan states, and each result takes 25 tap reads of the line
// store, a drain of the multiply-add pipeline, one quotient bit per cycle
// from the restoring divider and an output word; no new pixel is taken
// until every result of the last one has gone out.
// Reset restores 1024x768 and the triangular weights and starts at pixel
// (0,0); the line store needs no clearing. While m_tready is low the result
// word holds and no pixel is taken.
module weighted_window_smoothing import wws_pkg::*; #(
	parameter int MAX_WIDTH   = 1024,
	parameter int WEIGHT_BITS = 8
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [PIX_W-1:0]      s_tdata,  // gray_pixel
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [TDATA_W-1:0]    m_tdata,  // smoothed_pixel, out_column, out_row
	output logic                  m_tlast,
	output logic                  m_tuser,  // end_of_image
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_addr,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	wws_cmd_t          cmd;
	wws_sts_t          sts;
	logic [PIX_W-1:0]  smoothed_pixel;
	logic [OCOL_W-1:0] out_column;
	logic [OROW_W-1:0] out_row;

	wws_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	wws_datapath #(
		.MAX_WIDTH   (MAX_WIDTH),
		.WEIGHT_BITS (WEIGHT_BITS)
	) u_datapath (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_we         (cfg_we),
		.cfg_addr       (cfg_addr),
		.cfg_data       (cfg_data),
		.pixel          (s_tdata),
		.cmd            (cmd),
		.sts            (sts),
		.smoothed_pixel (smoothed_pixel),
		.out_column     (out_column),
		.out_row        (out_row),
		.last_of_run    (m_tlast),
		.end_of_image   (m_tuser)
	);

	assign m_tdata = {2'b00, out_row, out_column, smoothed_pixel};

endmodule

// ===== dv/tb.sv =====
`timescale 1ns / 1ps
module tb;
	import wws_pkg::*;

	typedef enum logic [1:0] {PIXEL, REG_WRITE, DRAIN} job_kind_t;

	typedef struct {
		job_kind_t             kind;
		logic [CFG_IDX_W-1:0]  idx;
		logic [CFG_DATA_W-1:0] value;
	} job_t;

	typedef struct {
		logic [PIX_W-1:0]  pix;
		logic [OCOL_W-1:0] col;
		logic [OROW_W-1:0] row;
		logic              last;
		logic              eoi;
	} smooth_word_t;

	localparam int STORE_W    = 1024;
	localparam int SETTLE     = 24;
	localparam int STALL_LIMIT = 5000;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  s_tvalid = 1'b0;
	logic                  s_tready;
	logic [PIX_W-1:0]      s_tdata = '0;
	logic                  m_tvalid;
	logic                  m_tready = 1'b0;
	logic [TDATA_W-1:0]    m_tdata;
	logic                  m_tlast;
	logic                  m_tuser;
	logic                  cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_addr = REG_IMAGE_WIDTH;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	weighted_window_smoothing dut (.*);

	job_t         pending_jobs[$];
	smooth_word_t expected_words[$];
	int           errors = 0;
	int           pixels_sent = 0;
	int           quiet = 0;
	int           idle_cycles = 0;
	logic         calm;

	// predictor state
	logic [PIX_W-1:0]      line_buf[5*STORE_W];
	int                    cur_col = 0;
	int                    cur_row = 0;
	logic [WIDTH_REG_W-1:0] width_reg = 11'd1024;
	logic [HGT_REG_W-1:0]  height_reg = 13'd768;
	logic [CFG_DATA_W-1:0] weight_rows[5] = '{40'h0102030201, 40'h0204060402,
		40'h0306090603, 40'h0204060402, 40'h0102030201};

	assign calm = pixels_sent >= 120 && pixels_sent < 175;

	initial forever #4 clk = ~clk;

	function automatic int eff_w();
		return width_reg == 0 ? 1 : (width_reg > STORE_W ? STORE_W : int'(width_reg));
	endfunction

	function automatic int eff_h();
		return height_reg == 0 ? 1 : (height_reg > MAX_HEIGHT ? MAX_HEIGHT : int'(height_reg));
	endfunction

	function automatic logic [PIX_W-1:0] window_mean(int oc, int orow, int w, int h);
		int unsigned acc;
		int unsigned wsum;
		int unsigned wt;
		int fy;
		int fx;
		acc = 0;
		wsum = 0;
		for (int dy = -2; dy <= 2; dy++) begin
			fy = orow + dy;
			if (fy < 0 || fy >= h) continue;
			for (int dx = -2; dx <= 2; dx++) begin
				fx = oc + dx;
				if (fx < 0 || fx >= w) continue;
				wt = 32'((weight_rows[dy+2] >> ((dx + 2) * 8)) & 40'hFF);
				acc += wt * line_buf[(fy % 5) * STORE_W + fx];
				wsum += wt;
			end
		end
		return wsum == 0 ? 8'd0 : PIX_W'(acc / wsum);
	endfunction

	task automatic apply_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
		if (idx == REG_IMAGE_WIDTH) begin
			width_reg = value[WIDTH_REG_W-1:0];
			cur_col = 0;
			cur_row = 0;
		end else if (idx == REG_IMAGE_HEIGHT) begin
			height_reg = value[HGT_REG_W-1:0];
			cur_col = 0;
			cur_row = 0;
		end else if (idx >= REG_WEIGHTS_ROW0 && idx <= REG_WEIGHTS_ROW4) begin
			weight_rows[idx - REG_WEIGHTS_ROW0] = value;
		end
	endtask

	task automatic predict_pixel(logic [PIX_W-1:0] pix);
		int w;
		int h;
		int c;
		int r;
		int clo;
		int chi;
		int rlo;
		int rhi;
		smooth_word_t e;
		w = eff_w();
		h = eff_h();
		c = cur_col;
		r = cur_row;
		if (c >= w || r >= h) begin
			c = 0;
			r = 0;
		end
		line_buf[(r % 5) * STORE_W + c] = pix;
		clo = c - 2;
		chi = clo;
		if (c == w - 1) begin
			if (clo < 0) clo = 0;
			chi = c;
		end
		rlo = r - 2;
		rhi = rlo;
		if (r == h - 1) begin
			if (rlo < 0) rlo = 0;
			rhi = r;
		end
		if (clo >= 0 && rlo >= 0) begin
			for (int orow = rlo; orow <= rhi; orow++) begin
				for (int oc = clo; oc <= chi; oc++) begin
					e.pix = window_mean(oc, orow, w, h);
					e.col = OCOL_W'(oc);
					e.row = OROW_W'(orow);
					e.last = orow == rhi && oc == chi;
					e.eoi = oc == w - 1 && orow == h - 1;
					expected_words.push_back(e);
				end
			end
		end
		c++;
		if (c >= w) begin
			c = 0;
			r++;
			if (r >= h) r = 0;
		end
		cur_col = c;
		cur_row = r;
	endtask

	task automatic report(string what, logic [31:0] got, logic [31:0] want);
		$display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
		errors++;
	endtask

	task automatic add_pixel(logic [PIX_W-1:0] v);
		pending_jobs.push_back('{PIXEL, REG_IMAGE_WIDTH, CFG_DATA_W'(v)});
	endtask

	task automatic add_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] v);
		pending_jobs.push_back('{REG_WRITE, idx, v});
	endtask

	function automatic logic [CFG_DATA_W-1:0] random_weights();
		case ($urandom_range(4))
			0: return '0;
			1: return '1;
			default: return {8'($urandom_range(255)), $urandom};
		endcase
	endfunction

	// driver
	always @(posedge clk or negedge arst_n) begin
		bit settled;
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata <= '0;
			cfg_we <= 1'b0;
			cfg_addr <= REG_IMAGE_WIDTH;
			cfg_data <= '0;
		end else begin
			settled = 0;
			if (s_tvalid && s_tready) begin
				predict_pixel(s_tdata);
				pixels_sent++;
			end
			if (!(s_tvalid && !s_tready)) begin
				if (pending_jobs.size() > 0 && pending_jobs[0].kind == PIXEL
						&& (calm || $urandom_range(99) >= 37)) begin
					s_tvalid <= 1'b1;
					s_tdata <= pending_jobs[0].value[PIX_W-1:0];
					void'(pending_jobs.pop_front());
				end else begin
					s_tvalid <= 1'b0;
					if (pending_jobs.size() > 0 && pending_jobs[0].kind != PIXEL
							&& !s_tvalid && expected_words.size() == 0 && quiet >= SETTLE)
						settled = 1;
				end
			end
			cfg_we <= settled && pending_jobs[0].kind == REG_WRITE;
			if (settled) begin
				if (pending_jobs[0].kind == REG_WRITE) begin
					cfg_addr <= pending_jobs[0].idx;
					cfg_data <= pending_jobs[0].value;
					apply_reg(pending_jobs[0].idx, pending_jobs[0].value);
				end
				void'(pending_jobs.pop_front());
			end
		end
	end

	// monitor
	always @(posedge clk or negedge arst_n) begin
		smooth_word_t e;
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			m_tready <= calm || $urandom_range(99) >= 37;
			if (m_tvalid && m_tready) begin
				if (expected_words.size() == 0) begin
					report("unexpected word", m_tdata, 0);
				end else begin
					e = expected_words.pop_front();
					if (m_tdata[7:0] !== e.pix) report("smoothed_pixel", m_tdata[7:0], e.pix);
					if (m_tdata[17:8] !== e.col) report("out_column", m_tdata[17:8], e.col);
					if (m_tdata[29:18] !== e.row) report("out_row", m_tdata[29:18], e.row);
					if (m_tdata[31:30] !== 2'b00) report("tdata padding", m_tdata[31:30], 0);
					if (m_tlast !== e.last) report("last_of_run", m_tlast, e.last);
					if (m_tuser !== e.eoi) report("end_of_image", m_tuser, e.eoi);
				end
			end
		end
	end

	// settle counter and watchdog
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || expected_words.size() != 0)
			quiet <= 0;
		else
			quiet <= quiet + 1;
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= STALL_LIMIT) begin
			$display("tb failed");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	initial begin
		int w;
		int h;
		int n;
		int cnt;
		bit paused;
		// a few words under the reset geometry: no results
		add_pixel(8'h00);
		add_pixel(8'hFF);
		add_pixel(8'h5A);
		// zero dimensions act as a 1x1 image
		add_reg(REG_IMAGE_WIDTH, '0);
		add_reg(REG_IMAGE_HEIGHT, '0);
		add_pixel(8'hFF);
		add_pixel(8'h00);
		add_pixel(8'hA5);
		// oversized dimensions saturate
		add_reg(REG_IMAGE_WIDTH, 40'h7FF);
		add_reg(REG_IMAGE_HEIGHT, 40'h1FFF);
		add_pixel(8'h81);
		add_pixel(8'h7E);
		// maximal weights, full-scale pixels
		for (int k = 0; k < 5; k++)
			add_reg(REG_WEIGHTS_ROW0 + CFG_IDX_W'(k), '1);
		add_reg(REG_IMAGE_WIDTH, 40'd3);
		add_reg(REG_IMAGE_HEIGHT, 40'd2);
		for (int i = 0; i < 6; i++)
			add_pixel(8'hFF);
		// zero weight sum
		for (int k = 0; k < 5; k++)
			add_reg(REG_WEIGHTS_ROW0 + CFG_IDX_W'(k), '0);
		for (int i = 0; i < 6; i++)
			add_pixel(PIX_W'($urandom_range(255)));
		n = 20;
		paused = 0;
		while (n < 270) begin
			w = $urandom_range(9) == 0 ? $urandom_range(12, 30) : $urandom_range(1, 9);
			h = $urandom_range(1, 7);
			add_reg(REG_IMAGE_WIDTH, CFG_DATA_W'(w));
			add_reg(REG_IMAGE_HEIGHT, CFG_DATA_W'(h));
			for (int k = 0; k < 5; k++)
				if ($urandom_range(1))
					add_reg(REG_WEIGHTS_ROW0 + CFG_IDX_W'(k), random_weights());
			cnt = w * h * int'($urandom_range(1, 2)) + int'($urandom_range(w));
			for (int i = 0; i < cnt && n < 270; i++) begin
				add_pixel(PIX_W'($urandom_range(255)));
				n++;
				if (!paused && n > 80 && i == 0) begin
					pending_jobs.push_back('{DRAIN, REG_IMAGE_WIDTH, '0});
					paused = 1;
				end
			end
		end
		repeat (2) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;
		while (pending_jobs.size() != 0 || s_tvalid || expected_words.size() != 0)
			@(posedge clk);
		repeat (60) @(posedge clk);
		if (errors == 0)
			$display("tb passed");
		else
			$display("tb failed");
		$finish;
	end

endmodule
